@@ rtl/core/epvs_pkg.sv @@
package epvs_pkg;

    // Most pions that enter the vector sum of one event.
    localparam int unsigned MAX_PIONS    = 16;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
    localparam int unsigned CNT_W        = 8;

    // Datapath widths of the shared CORDIC unit.
    localparam int unsigned XW = 27;
    localparam int unsigned ZW = 27;

    localparam logic signed [17:0] DEG180_Q7 = 18'sd23040;
    localparam logic signed [17:0] DEG90_Q7  = 18'sd11520;
    localparam logic signed [17:0] DEG360_Q7 = 18'sd46080;
    localparam logic signed [ZW-1:0] DEG180_Z = ZW'(23040 * 512);
    localparam logic [15:0] GAIN_COMP = 16'd39797;

    localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] ACC_MIN = 24'sh800000;

    typedef enum logic
    {
        CORDIC_VECTOR = 1'b0,
        CORDIC_ROTATE = 1'b1
    } cordic_mode_t;

    typedef struct packed
    {
        logic         start;
        cordic_mode_t mode;
    } cordic_ctrl_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in degrees scaled by 2^16.
    function automatic logic signed [ZW-1:0] atan_deg16(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            4'd0:    r = ZW'(2949120);
            4'd1:    r = ZW'(1740967);
            4'd2:    r = ZW'(919879);
            4'd3:    r = ZW'(466945);
            4'd4:    r = ZW'(234379);
            4'd5:    r = ZW'(117304);
            4'd6:    r = ZW'(58666);
            4'd7:    r = ZW'(29335);
            4'd8:    r = ZW'(14668);
            4'd9:    r = ZW'(7334);
            4'd10:   r = ZW'(3667);
            4'd11:   r = ZW'(1833);
            4'd12:   r = ZW'(917);
            4'd13:   r = ZW'(458);
            4'd14:   r = ZW'(229);
            default: r = ZW'(115);
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/epvs_in_if.sv @@
interface epvs_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [31:0]        event_number;
    logic signed [31:0] gen_code;
    logic signed [31:0] det_code;
    logic [15:0]        zh_in;
    logic [19:0]        pt2_in;
    logic signed [15:0] phi_in;

    modport source (output valid, func, event_number, gen_code, det_code, zh_in, pt2_in,
                    phi_in, input ready);
    modport sink (input valid, func, event_number, gen_code, det_code, zh_in, pt2_in,
                  phi_in, output ready);
endinterface

@@ rtl/core/epvs_out_if.sv @@
interface epvs_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        event_out;
    logic [7:0]         gen_count;
    logic [7:0]         det_count;
    logic [19:0]        zh_sum;
    logic [27:0]        pt2_sum;
    logic signed [16:0] phi_sum;
    logic               overflow;

    modport source (output valid, event_out, gen_count, det_count, zh_sum, pt2_sum,
                    phi_sum, overflow, input ready);
    modport sink (input valid, event_out, gen_count, det_count, zh_sum, pt2_sum,
                  phi_sum, overflow, output ready);
endinterface

@@ rtl/core/event_pion_vector_sum.sv @@
// Groups consecutive particle requests by event number and closes an event with one result
// when the event number changes or a flush request arrives. A request is taken only while the
// block is idle. A flush with no open event returns straight to idle. A record that is not a
// summed pion passes through the accept and the update steps. A summed generated pion passes
// through accept, update, an 18-step square root, one gain multiply, 16 CORDIC rotation steps
// and the accumulate step. Closing an event squares x and then y, runs 16 CORDIC vectoring
// steps and hands over into the output register, waiting while the previous result has not
// yet been taken. One CORDIC unit serves both rotation and vectoring.
module event_pion_vector_sum
    import epvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    epvs_in_if.sink     req,
    epvs_out_if.source  res
);

    typedef enum logic [9:0]
    {
        S_IDLE = 10'b0000000001,
        S_SQR  = 10'b0000000010,
        S_SQR2 = 10'b0000000100,
        S_VEC  = 10'b0000001000,
        S_EMIT = 10'b0000010000,
        S_UPD  = 10'b0000100000,
        S_SQRT = 10'b0001000000,
        S_GAIN = 10'b0010000000,
        S_ROT  = 10'b0100000000,
        S_ACC  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] pion_code_reg;

    // Latched request.
    logic               func_reg;
    logic [31:0]        ev_reg;
    logic               gen_hit_reg, det_hit_reg;
    logic [15:0]        zh_reg;
    logic [19:0]        pt2_reg;
    logic signed [15:0] phi_reg;

    // Event state.
    logic               event_open_reg;
    logic [31:0]        current_event_reg;
    logic [CNT_W-1:0]   gen_counter_reg, det_counter_reg;
    logic [19:0]        zh_accum_reg;
    logic signed [23:0] x_accum_reg, y_accum_reg;
    logic               overflow_flag_reg;

    // Closing datapath.
    logic [47:0]          sq_reg;
    logic                 zero_vec_reg;
    logic signed [ZW-1:0] base_reg;

    // Square root datapath.
    logic [35:0] rem_reg;
    logic [36:0] root_reg;
    logic [4:0]  sqrt_k_reg;

    logic                 flip_reg;
    logic                 out_valid_reg;
    logic [31:0]          event_out_reg;
    logic [7:0]           gen_count_reg, det_count_reg;
    logic [19:0]          zh_sum_reg;
    logic [27:0]          pt2_sum_reg;
    logic signed [16:0]   phi_sum_reg;
    logic                 overflow_out_reg;

    cordic_ctrl_t         cctrl;
    cordic_stat_t         cstat;
    logic signed [XW-1:0] c_x_in, c_y_in, c_x, c_y;
    logic signed [ZW-1:0] c_z_in, c_z;

    epvs_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cctrl),
        .x_in  (c_x_in),
        .y_in  (c_y_in),
        .z_in  (c_z_in),
        .x     (c_x),
        .y     (c_y),
        .z     (c_z),
        .stat  (cstat)
    );

    logic accept;
    logic out_free;
    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Squaring for the length of the vector sum: x in S_SQR, y in S_SQR2.
    logic signed [23:0] sq_op;
    logic signed [47:0] sq_prod;
    assign sq_op   = (state_reg == S_SQR) ? x_accum_reg : y_accum_reg;
    assign sq_prod = sq_op * sq_op;

    // Vectoring start: a vector in the left half-plane is turned by 180 degrees first.
    logic signed [XW-1:0] vx_ext, vy_ext;
    logic                 vneg;
    assign vx_ext = XW'(x_accum_reg);
    assign vy_ext = XW'(y_accum_reg);
    assign vneg   = x_accum_reg[23];

    // Rotation angle: phi plus 180 degrees, wrapped, folded into the right half-plane.
    logic signed [17:0] ang_raw, ang_wrap, ang_fold;
    logic               ang_flip;
    always_comb
    begin
        ang_raw  = 18'(phi_reg) + DEG180_Q7;
        ang_wrap = (ang_raw >= DEG180_Q7) ? ang_raw - DEG360_Q7 : ang_raw;
        ang_flip = 1'b0;
        ang_fold = ang_wrap;
        if (ang_wrap > DEG90_Q7)
        begin
            ang_fold = ang_wrap - DEG180_Q7;
            ang_flip = 1'b1;
        end
        else if (ang_wrap < -DEG90_Q7)
        begin
            ang_fold = ang_wrap + DEG180_Q7;
            ang_flip = 1'b1;
        end
    end

    // Gain-compensated magnitude for the rotation.
    logic [33:0] gain_prod;
    assign gain_prod = root_reg[17:0] * GAIN_COMP;

    always_comb
    begin
        cctrl.start = 1'b0;
        cctrl.mode  = CORDIC_VECTOR;
        c_x_in      = vneg ? -vx_ext : vx_ext;
        c_y_in      = vneg ? -vy_ext : vy_ext;
        c_z_in      = '0;
        if (state_reg == S_SQR2)
        begin
            cctrl.start = 1'b1;
        end
        else if (state_reg == S_GAIN)
        begin
            cctrl.start = 1'b1;
            cctrl.mode  = CORDIC_ROTATE;
            c_x_in      = XW'(gain_prod[33:16]);
            c_y_in      = '0;
            c_z_in      = ZW'(ang_fold) <<< 9;
        end
    end

    // Square root step: trial subtraction of root plus the current bit.
    logic [36:0] sqrt_bit, sqrt_trial;
    assign sqrt_bit   = 37'd1 << {sqrt_k_reg, 1'b0};
    assign sqrt_trial = root_reg + sqrt_bit;

    // Closing angle, rounded to Q7 and clamped to a half turn.
    logic signed [ZW:0]  ang_sum;
    logic signed [17:0]  ang_q7, ang_clamp;
    always_comb
    begin
        ang_sum = (ZW+1)'(base_reg) + (ZW+1)'(c_z) + (ZW+1)'(256);
        ang_q7  = 18'(ang_sum >>> 9);
        if (zero_vec_reg)
        begin
            ang_clamp = '0;
        end
        else if (ang_q7 > DEG180_Q7)
        begin
            ang_clamp = DEG180_Q7;
        end
        else if (ang_q7 < -DEG180_Q7)
        begin
            ang_clamp = -DEG180_Q7;
        end
        else
        begin
            ang_clamp = ang_q7;
        end
    end

    logic [31:0] len_q16;
    assign len_q16 = sq_reg[47:16];

    // Accumulation of a rotated pion with saturation.
    logic signed [XW-1:0] rx, ry;
    logic signed [XW:0]   sx, sy;
    assign rx = flip_reg ? -c_x : c_x;
    assign ry = flip_reg ? -c_y : c_y;
    assign sx = (XW+1)'(x_accum_reg) + (XW+1)'(rx);
    assign sy = (XW+1)'(y_accum_reg) + (XW+1)'(ry);

    function automatic logic signed [23:0] sat24(input logic signed [XW:0] v);
        logic signed [23:0] r;
        if (v > (XW+1)'(ACC_MAX))
        begin
            r = ACC_MAX;
        end
        else if (v < (XW+1)'(ACC_MIN))
        begin
            r = ACC_MIN;
        end
        else
        begin
            r = 24'(v);
        end
        return r;
    endfunction

    logic [20:0] zh_add;
    assign zh_add = 21'(zh_accum_reg) + 21'(zh_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func)
                    begin
                        state_next = event_open_reg ? S_SQR : S_IDLE;
                    end
                    else if (event_open_reg && (req.event_number != current_event_reg))
                    begin
                        state_next = S_SQR;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_SQR:  state_next = S_SQR2;
            S_SQR2: state_next = S_VEC;
            S_VEC:  state_next = cstat.done ? S_EMIT : S_VEC;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = func_reg ? S_IDLE : S_UPD;
                end
            end
            S_UPD:
            begin
                if (gen_hit_reg && (gen_counter_reg < CNT_W'(MAX_PIONS)))
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SQRT: state_next = (sqrt_k_reg == '0) ? S_GAIN : S_SQRT;
            S_GAIN: state_next = S_ROT;
            S_ROT:  state_next = cstat.done ? S_ACC : S_ROT;
            S_ACC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pion_code_reg     <= 32'd211;
            event_open_reg    <= 1'b0;
            current_event_reg <= '0;
            gen_counter_reg   <= '0;
            det_counter_reg   <= '0;
            zh_accum_reg      <= '0;
            x_accum_reg       <= '0;
            y_accum_reg       <= '0;
            overflow_flag_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                pion_code_reg <= cfg_data;
            end
            // A new result loaded in the same cycle keeps the valid flag set.
            if (res.valid && res.ready && !((state_reg == S_EMIT) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        gen_counter_reg   <= '0;
                        det_counter_reg   <= '0;
                        zh_accum_reg      <= '0;
                        x_accum_reg       <= '0;
                        y_accum_reg       <= '0;
                        overflow_flag_reg <= 1'b0;
                        if (func_reg)
                        begin
                            event_open_reg <= 1'b0;
                        end
                    end
                end
                S_UPD:
                begin
                    event_open_reg    <= 1'b1;
                    current_event_reg <= ev_reg;
                    if (det_hit_reg && (det_counter_reg != '1))
                    begin
                        det_counter_reg <= det_counter_reg + 1'b1;
                    end
                    if (gen_hit_reg)
                    begin
                        if (gen_counter_reg != '1)
                        begin
                            gen_counter_reg <= gen_counter_reg + 1'b1;
                        end
                        if (gen_counter_reg < CNT_W'(MAX_PIONS))
                        begin
                            zh_accum_reg <= zh_add[20] ? 20'hFFFFF : zh_add[19:0];
                        end
                        else
                        begin
                            overflow_flag_reg <= 1'b1;
                        end
                    end
                end
                S_ACC:
                begin
                    x_accum_reg <= sat24(sx);
                    y_accum_reg <= sat24(sy);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            ev_reg      <= req.event_number;
            gen_hit_reg <= (req.gen_code == pion_code_reg);
            det_hit_reg <= (req.det_code == pion_code_reg);
            zh_reg      <= req.zh_in;
            pt2_reg     <= req.pt2_in;
            phi_reg     <= req.phi_in;
        end
        if (state_reg == S_SQR)
        begin
            sq_reg <= 48'(sq_prod);
        end
        if (state_reg == S_SQR2)
        begin
            sq_reg       <= sq_reg + 48'(sq_prod);
            zero_vec_reg <= (x_accum_reg == '0) && (y_accum_reg == '0);
            base_reg     <= !vneg ? '0 : (y_accum_reg[23] ? -DEG180_Z : DEG180_Z);
        end
        if (state_reg == S_UPD)
        begin
            rem_reg    <= {pt2_reg, 16'd0};
            root_reg   <= '0;
            sqrt_k_reg <= 5'd17;
        end
        if (state_reg == S_SQRT)
        begin
            if (37'(rem_reg) >= sqrt_trial)
            begin
                rem_reg  <= 36'(37'(rem_reg) - sqrt_trial);
                root_reg <= (root_reg >> 1) + sqrt_bit;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            sqrt_k_reg <= sqrt_k_reg - 1'b1;
        end
        if (state_reg == S_GAIN)
        begin
            flip_reg <= ang_flip;
        end
        if ((state_reg == S_EMIT) && out_free)
        begin
            event_out_reg    <= current_event_reg;
            gen_count_reg    <= gen_counter_reg;
            det_count_reg    <= det_counter_reg;
            zh_sum_reg       <= zh_accum_reg;
            pt2_sum_reg      <= (len_q16[31:28] != '0) ? 28'hFFFFFFF : len_q16[27:0];
            phi_sum_reg      <= 17'(ang_clamp - DEG180_Q7);
            overflow_out_reg <= overflow_flag_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.event_out = event_out_reg;
    assign res.gen_count = gen_count_reg;
    assign res.det_count = det_count_reg;
    assign res.zh_sum    = zh_sum_reg;
    assign res.pt2_sum   = pt2_sum_reg;
    assign res.phi_sum   = phi_sum_reg;
    assign res.overflow  = overflow_out_reg;

    // Pions are left out of the sum only once the summing limit has been passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_flag_reg |-> (gen_counter_reg > CNT_W'(MAX_PIONS)))
        else $error("overflow flag set below the pion limit");

    // The CORDIC unit only runs while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cstat.busy |-> ((state_reg == S_VEC) || (state_reg == S_ROT)))
        else $error("CORDIC busy outside its wait states");

    // With no open event all event accumulators are empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !event_open_reg |-> ((gen_counter_reg == '0) && (det_counter_reg == '0)
                             && (zh_accum_reg == '0) && (x_accum_reg == '0)
                             && (y_accum_reg == '0)))
        else $error("accumulators not clear while no event is open");

endmodule

@@ rtl/core/epvs_cordic.sv @@
// Iterative CORDIC: one micro-rotation a cycle, rotation or vectoring mode.
module epvs_cordic
    import epvs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_ctrl_t         ctrl,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [XW-1:0] x,
    output logic signed [XW-1:0] y,
    output logic signed [ZW-1:0] z,
    output cordic_stat_t         stat
);

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    cordic_mode_t         mode_reg;
    logic signed [XW-1:0] xs, ys;
    logic                 dir_pos;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    // Positive direction turns the vector anticlockwise and lowers z.
    assign dir_pos = (mode_reg == CORDIC_ROTATE) ? !z_reg[ZW-1] : y_reg[XW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            mode_reg <= CORDIC_VECTOR;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            mode_reg <= ctrl.mode;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            if (dir_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_deg16(step_reg);
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_deg16(step_reg);
            end
        end
    end

    assign x         = x_reg;
    assign y         = y_reg;
    assign z         = z_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (step_reg == STEP_W'(CORDIC_STEPS - 1));

endmodule
